// File: rtl/obc_pkg.sv
// obc_pkg: shared types and constants of the online bridge counter.
// Holds the transfer payload structs, outcome codes and the
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package obc_pkg;

  localparam int unsigned NODES_DEF = 1024;
  localparam int unsigned VERT_W    = 10;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned OUTC_W    = 2;
  localparam int unsigned EPOCH_W   = 16;
  localparam int unsigned COUNT_MAX = 1023;

  localparam logic [OUTC_W-1:0] OUTC_SAME   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_BRIDGE = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_CYCLE  = 2'd2;

  typedef struct packed {
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bridge_count;
    logic [OUTC_W-1:0]  edge_outcome;
  } out_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_ACCEPT, OP_CLEAR, OP_R_START, OP_R_CHASE, OP_C_ISSUE, OP_C_STEP,
    OP_SV_A, OP_GOT_A, OP_GOT_B, OP_CC_INIT, OP_CC_RD, OP_CC_CHK, OP_CC_RET,
    OP_CP_RD, OP_CP_W, OP_CP_RET, OP_CC_DONE, OP_SZ_A, OP_SZ_B, OP_SZ_CMP,
    OP_RR_INIT, OP_RR_RD, OP_RR_P, OP_RR_RET, OP_RR_END, OP_RR_SZ, OP_LINK,
    OP_SZ_ADD, OP_EPOCH, OP_STAMP_CLR, OP_MG_INIT, OP_MG_SVA, OP_MARK_RD,
    OP_MA_CHK, OP_MG_SVB, OP_MB_CHK, OP_MG_NEXT, OP_RW_INIT, OP_RW_SV,
    OP_RW_GOT, OP_RW_NXT, OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic r_stop;
    logic c_stop;
    logic ab_eq;
    logic cc_stop;
    logic cp_stop;
    logic cc_eq;
    logic rr_stop;
    logic tp_none;
    logic epoch_wrap;
    logic sweep_last;
    logic mg_stop;
    logic xa_none;
    logic xb_none;
    logic stamp_hit;
    logic rw_stop;
    logic at_meet;
    logic out_free;
  } status_t;

endpackage

// File: rtl/obc_dpath.sv
// obc_dpath: datapath of the online bridge counter.
// Holds the forest and union-find memories, walk registers and the output
// register; acts on obc_pkg::cmd_t and reports obc_pkg::status_t.
`timescale 1ns / 1ps

module obc_dpath #(
  parameter int unsigned NODES = obc_pkg::NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  obc_pkg::cmd_t    cmd_i,
  output obc_pkg::status_t st_o,
  input  obc_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output obc_pkg::out_t    out_data_o
);
  import obc_pkg::*;

  localparam int unsigned VW   = $clog2(NODES);
  localparam int unsigned SW   = VW + 1;
  localparam int unsigned CNTW = VW + 2;
  localparam logic [CNTW-1:0] CNT_N  = CNTW'(NODES);
  localparam logic [CNTW-1:0] CNT_2N = CNTW'(2 * NODES);
  localparam logic [VW:0]     RCNT_N = SW'(NODES);
  localparam logic [VW-1:0]   LAST   = VW'(NODES - 1);

  // memories: parent (msb = none), component link, edge-biconnected link, size, stamp
  logic [VW:0]        tp_mem  [NODES];
  logic [VW-1:0]      cl_mem  [NODES];
  logic [VW-1:0]      tel_mem [NODES];
  logic [SW-1:0]      sz_mem  [NODES];
  logic [EPOCH_W-1:0] st_mem  [NODES];

  logic [VW:0]        tp_rd;
  logic [VW-1:0]      cl_rd, tel_rd;
  logic [SW-1:0]      sz_rd;
  logic [EPOCH_W-1:0] st_rd;

  logic [VW-1:0]      raddr, waddr;
  logic               tp_we, cl_we, tel_we, sz_we, st_we;
  logic [VW:0]        tp_wd;
  logic [VW-1:0]      cl_wd, tel_wd;
  logic [SW-1:0]      sz_wd;
  logic [EPOCH_W-1:0] st_wd;

  logic [VW-1:0]      a_q, b_q, sv_q, r_q, u_q, cr_q, cu_q, ca_q, cb_q;
  logic [VW-1:0]      rv_q, child_q, xa_q, xb_q, meet_q, y_q;
  logic               rv_none_q, child_none_q, xa_none_q, xb_none_q, y_none_q;
  logic               in_range_q;
  logic [VW:0]        rcnt_q;
  logic [CNTW-1:0]    ocnt_q;
  logic [SW-1:0]      sa_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [VW-1:0]      bridge_q;
  logic [OUTC_W-1:0]  outcome_q;
  logic               out_valid_q;
  out_t               out_q;
  logic [VW-1:0]      sel_v;
  logic [COUNT_W-1:0] count_sat;

  assign sel_v = cmd_i.sel ? b_q : a_q;
  assign count_sat = (32'(bridge_q) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                 : COUNT_W'(bridge_q);

  always_ff @(posedge clk_i) begin
    if (tp_we) tp_mem[waddr] <= tp_wd;
    tp_rd <= tp_mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (cl_we) cl_mem[waddr] <= cl_wd;
    cl_rd <= cl_mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (tel_we) tel_mem[waddr] <= tel_wd;
    tel_rd <= tel_mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (sz_we) sz_mem[waddr] <= sz_wd;
    sz_rd <= sz_mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[waddr] <= st_wd;
    st_rd <= st_mem[raddr];
  end

  always_comb begin
    st_o.in_range   = in_range_q;
    st_o.r_stop     = (tel_rd == r_q) || (rcnt_q >= RCNT_N);
    st_o.c_stop     = (u_q == r_q) || (rcnt_q >= RCNT_N);
    st_o.ab_eq      = (a_q == r_q);
    st_o.cc_stop    = (cl_rd == cr_q) || (ocnt_q >= CNT_N);
    st_o.cp_stop    = (cu_q == cr_q) || (ocnt_q >= CNT_N);
    st_o.cc_eq      = (ca_q == cb_q);
    st_o.rr_stop    = rv_none_q || (ocnt_q >= CNT_N);
    st_o.tp_none    = tp_rd[VW];
    st_o.epoch_wrap = &epoch_q;
    st_o.sweep_last = (ocnt_q[VW-1:0] == LAST);
    st_o.mg_stop    = (ocnt_q > CNT_2N) || (xa_none_q && xb_none_q);
    st_o.xa_none    = xa_none_q;
    st_o.xb_none    = xb_none_q;
    st_o.stamp_hit  = (st_rd == epoch_q);
    st_o.rw_stop    = y_none_q || (ocnt_q >= CNT_N);
    st_o.at_meet    = (r_q == meet_q);
    st_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // memory port control
  always_comb begin
    raddr  = '0;
    waddr  = '0;
    tp_we  = 1'b0;
    cl_we  = 1'b0;
    tel_we = 1'b0;
    sz_we  = 1'b0;
    st_we  = 1'b0;
    tp_wd  = '0;
    cl_wd  = '0;
    tel_wd = '0;
    sz_wd  = '0;
    st_wd  = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        waddr  = ocnt_q[VW-1:0];
        tp_we  = 1'b1;
        tp_wd  = {1'b1, {VW{1'b0}}};
        cl_we  = 1'b1;
        cl_wd  = ocnt_q[VW-1:0];
        tel_we = 1'b1;
        tel_wd = ocnt_q[VW-1:0];
        sz_we  = 1'b1;
        sz_wd  = SW'(1);
        st_we  = 1'b1;
      end
      OP_STAMP_CLR: begin
        waddr = ocnt_q[VW-1:0];
        st_we = 1'b1;
      end
      OP_R_START:  raddr = sv_q;
      OP_R_CHASE:  raddr = tel_rd;
      OP_C_ISSUE:  raddr = u_q;
      OP_C_STEP: begin
        raddr  = tel_rd;
        waddr  = u_q;
        tel_we = 1'b1;
        tel_wd = r_q;
      end
      OP_CC_RD:    raddr = cr_q;
      OP_CP_RD:    raddr = cu_q;
      OP_CP_W: begin
        waddr = cu_q;
        cl_we = 1'b1;
        cl_wd = cr_q;
      end
      OP_SZ_A:     raddr = ca_q;
      OP_SZ_B:     raddr = cb_q;
      OP_RR_RD:    raddr = rv_q;
      OP_RR_P: begin
        waddr = rv_q;
        tp_we = 1'b1;
        tp_wd = {child_none_q, child_q};
        cl_we = 1'b1;
        cl_wd = a_q;
      end
      OP_RR_END:   raddr = child_q;
      OP_RR_SZ: begin
        waddr = a_q;
        sz_we = !child_none_q;
        sz_wd = sz_rd;
      end
      OP_LINK: begin
        raddr = cb_q;
        waddr = a_q;
        tp_we = 1'b1;
        tp_wd = {1'b0, b_q};
        cl_we = 1'b1;
        cl_wd = b_q;
      end
      OP_SZ_ADD: begin
        waddr = cb_q;
        sz_we = 1'b1;
        sz_wd = sz_rd + sa_q;
      end
      OP_MARK_RD:  raddr = r_q;
      OP_MA_CHK, OP_MB_CHK: begin
        waddr = r_q;
        st_we = !st_o.stamp_hit;
        st_wd = epoch_q;
      end
      OP_RW_GOT: begin
        raddr  = r_q;
        waddr  = r_q;
        tel_we = 1'b1;
        tel_wd = meet_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q      <= '0;
      epoch_q     <= '0;
      bridge_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR, OP_MG_NEXT: ocnt_q <= ocnt_q + 1'b1;
        OP_STAMP_CLR: begin
          ocnt_q <= ocnt_q + 1'b1;
          if (st_o.sweep_last) epoch_q <= EPOCH_W'(1);
        end
        OP_CC_INIT, OP_RR_INIT, OP_MG_INIT, OP_RW_INIT: ocnt_q <= '0;
        OP_CC_CHK:  if (st_o.cc_stop) ocnt_q <= '0;
        OP_CC_RET, OP_CP_RET, OP_RR_P: ocnt_q <= ocnt_q + 1'b1;
        OP_SZ_A:    bridge_q <= bridge_q + 1'b1;
        OP_EPOCH: begin
          epoch_q <= epoch_q + 1'b1;
          ocnt_q  <= '0;
        end
        OP_RW_GOT: begin
          if (!st_o.at_meet) begin
            ocnt_q <= ocnt_q + 1'b1;
            if (bridge_q != '0) bridge_q <= bridge_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        a_q        <= VW'(in_data_i.vertex_a);
        b_q        <= VW'(in_data_i.vertex_b);
        in_range_q <= (32'(in_data_i.vertex_a) < NODES)
                   && (32'(in_data_i.vertex_b) < NODES);
        outcome_q  <= OUTC_SAME;
      end
      OP_R_START: begin
        r_q    <= sv_q;
        rcnt_q <= '0;
      end
      OP_R_CHASE: begin
        if (!st_o.r_stop) begin
          r_q    <= tel_rd;
          rcnt_q <= rcnt_q + 1'b1;
        end else begin
          u_q    <= sv_q;
          rcnt_q <= '0;
        end
      end
      OP_C_STEP: begin
        u_q    <= tel_rd;
        rcnt_q <= rcnt_q + 1'b1;
      end
      OP_SV_A:   sv_q <= a_q;
      OP_GOT_A: begin
        a_q  <= r_q;
        sv_q <= b_q;
      end
      OP_GOT_B:   b_q <= r_q;
      OP_CC_INIT: cr_q <= sel_v;
      OP_CC_CHK: begin
        if (st_o.cc_stop) cu_q <= sel_v;
        else sv_q <= cl_rd;
      end
      OP_CC_RET:  cr_q <= r_q;
      OP_CP_W:    sv_q <= cl_rd;
      OP_CP_RET:  cu_q <= r_q;
      OP_CC_DONE: begin
        if (cmd_i.sel) cb_q <= cr_q;
        else ca_q <= cr_q;
      end
      OP_SZ_B:    sa_q <= sz_rd;
      OP_SZ_CMP: begin
        if (sa_q > sz_rd) begin
          a_q  <= b_q;
          b_q  <= a_q;
          ca_q <= cb_q;
          cb_q <= ca_q;
        end
      end
      OP_RR_INIT: begin
        rv_q         <= a_q;
        rv_none_q    <= 1'b0;
        child_none_q <= 1'b1;
      end
      OP_RR_P: begin
        child_q      <= rv_q;
        child_none_q <= 1'b0;
        sv_q         <= tp_rd[VW-1:0];
        if (tp_rd[VW]) rv_none_q <= 1'b1;
      end
      OP_RR_RET:  rv_q <= r_q;
      OP_RR_SZ:   sa_q <= sz_rd;
      OP_SZ_ADD:  outcome_q <= OUTC_BRIDGE;
      OP_EPOCH:   outcome_q <= OUTC_CYCLE;
      OP_MG_INIT: begin
        xa_q      <= a_q;
        xa_none_q <= 1'b0;
        xb_q      <= b_q;
        xb_none_q <= 1'b0;
      end
      OP_MG_SVA:  sv_q <= xa_q;
      OP_MG_SVB:  sv_q <= xb_q;
      OP_MA_CHK: begin
        if (st_o.stamp_hit) begin
          meet_q <= r_q;
        end else begin
          xa_q      <= tp_rd[VW-1:0];
          xa_none_q <= tp_rd[VW];
        end
      end
      OP_MB_CHK: begin
        if (st_o.stamp_hit) begin
          meet_q <= r_q;
        end else begin
          xb_q      <= tp_rd[VW-1:0];
          xb_none_q <= tp_rd[VW];
        end
      end
      OP_RW_INIT: begin
        y_q      <= sel_v;
        y_none_q <= 1'b0;
      end
      OP_RW_SV:   sv_q <= y_q;
      OP_RW_NXT: begin
        y_q      <= tp_rd[VW-1:0];
        y_none_q <= tp_rd[VW];
      end
      OP_FIN: begin
        out_q.bridge_count <= count_sat;
        out_q.edge_outcome <= outcome_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_bridge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bridge_q) < NODES)
    else $error("bridge total beyond forest edge count");
  a_fin_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN) |-> (outcome_q == OUTC_SAME || outcome_q == OUTC_BRIDGE
                              || outcome_q == OUTC_CYCLE))
    else $error("result outcome code out of range");
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MG_INIT) |-> (epoch_q != '0))
    else $error("path walk started with a zero epoch");
`endif

endmodule

// File: rtl/obc_ctrl.sv
// obc_ctrl: sequencer of the online bridge counter.
// One-hot state machine with a return register for the shared
// representative-lookup routine; uses obc_pkg command/status types.
`timescale 1ns / 1ps

module obc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  obc_pkg::status_t st_i,
  output obc_pkg::cmd_t    cmd_o
);
  import obc_pkg::*;

  localparam int unsigned NS = 45;

  typedef enum logic [NS-1:0] {
    S_CLEAR     = 45'h1 << 0,  S_IDLE      = 45'h1 << 1,
    S_START     = 45'h1 << 2,  S_A_DONE    = 45'h1 << 3,
    S_B_DONE    = 45'h1 << 4,  S_CC_INIT   = 45'h1 << 5,
    S_CC_RD     = 45'h1 << 6,  S_CC_CHK    = 45'h1 << 7,
    S_CC_RET    = 45'h1 << 8,  S_CP_RD     = 45'h1 << 9,
    S_CP_W      = 45'h1 << 10, S_CP_RET    = 45'h1 << 11,
    S_CC_DONE   = 45'h1 << 12, S_CMP       = 45'h1 << 13,
    S_SZ_A      = 45'h1 << 14, S_SZ_B      = 45'h1 << 15,
    S_SZ_CMP    = 45'h1 << 16, S_RR_INIT   = 45'h1 << 17,
    S_RR_TOP    = 45'h1 << 18, S_RR_P      = 45'h1 << 19,
    S_RR_RET    = 45'h1 << 20, S_RR_END    = 45'h1 << 21,
    S_RR_SZ     = 45'h1 << 22, S_LINK      = 45'h1 << 23,
    S_SZ_ADD    = 45'h1 << 24, S_EPOCH     = 45'h1 << 25,
    S_STAMP_CLR = 45'h1 << 26, S_MG_INIT   = 45'h1 << 27,
    S_MG_TOP    = 45'h1 << 28, S_MA_GOT    = 45'h1 << 29,
    S_MA_CHK    = 45'h1 << 30, S_MB        = 45'h1 << 31,
    S_MB_GOT    = 45'h1 << 32, S_MB_CHK    = 45'h1 << 33,
    S_MG_NEXT   = 45'h1 << 34, S_RW_INIT   = 45'h1 << 35,
    S_RW_TOP    = 45'h1 << 36, S_RW_GOT    = 45'h1 << 37,
    S_RW_NXT    = 45'h1 << 38, S_RW_SIDE   = 45'h1 << 39,
    S_FIN       = 45'h1 << 40, S_R_ISSUE   = 45'h1 << 41,
    S_R_CHASE   = 45'h1 << 42, S_C_ISSUE   = 45'h1 << 43,
    S_C_STEP    = 45'h1 << 44
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic   sel_q, sel_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    sel_d      = sel_q;
    cmd_o.op   = OP_NOP;
    cmd_o.sel  = sel_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (st_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_START;
        end
      end
      S_START: begin
        cmd_o.op = OP_SV_A;
        if (!st_i.in_range) begin
          state_d = S_FIN;
        end else begin
          ret_d   = S_A_DONE;
          state_d = S_R_ISSUE;
        end
      end
      S_A_DONE: begin
        cmd_o.op = OP_GOT_A;
        ret_d    = S_B_DONE;
        state_d  = S_R_ISSUE;
      end
      S_B_DONE: begin
        cmd_o.op = OP_GOT_B;
        sel_d    = 1'b0;
        state_d  = st_i.ab_eq ? S_FIN : S_CC_INIT;
      end
      S_CC_INIT: begin
        cmd_o.op = OP_CC_INIT;
        state_d  = S_CC_RD;
      end
      S_CC_RD: begin
        cmd_o.op = OP_CC_RD;
        state_d  = S_CC_CHK;
      end
      S_CC_CHK: begin
        cmd_o.op = OP_CC_CHK;
        if (st_i.cc_stop) begin
          state_d = S_CP_RD;
        end else begin
          ret_d   = S_CC_RET;
          state_d = S_R_ISSUE;
        end
      end
      S_CC_RET: begin
        cmd_o.op = OP_CC_RET;
        state_d  = S_CC_RD;
      end
      S_CP_RD: begin
        cmd_o.op = OP_CP_RD;
        state_d  = st_i.cp_stop ? S_CC_DONE : S_CP_W;
      end
      S_CP_W: begin
        cmd_o.op = OP_CP_W;
        ret_d    = S_CP_RET;
        state_d  = S_R_ISSUE;
      end
      S_CP_RET: begin
        cmd_o.op = OP_CP_RET;
        state_d  = S_CP_RD;
      end
      S_CC_DONE: begin
        cmd_o.op = OP_CC_DONE;
        if (sel_q) begin
          state_d = S_CMP;
        end else begin
          sel_d   = 1'b1;
          state_d = S_CC_INIT;
        end
      end
      S_CMP: begin
        sel_d   = 1'b0;
        state_d = st_i.cc_eq ? S_EPOCH : S_SZ_A;
      end
      S_SZ_A: begin
        cmd_o.op = OP_SZ_A;
        state_d  = S_SZ_B;
      end
      S_SZ_B: begin
        cmd_o.op = OP_SZ_B;
        state_d  = S_SZ_CMP;
      end
      S_SZ_CMP: begin
        cmd_o.op = OP_SZ_CMP;
        state_d  = S_RR_INIT;
      end
      S_RR_INIT: begin
        cmd_o.op = OP_RR_INIT;
        state_d  = S_RR_TOP;
      end
      S_RR_TOP: begin
        cmd_o.op = OP_RR_RD;
        state_d  = st_i.rr_stop ? S_RR_END : S_RR_P;
      end
      S_RR_P: begin
        cmd_o.op = OP_RR_P;
        if (st_i.tp_none) begin
          state_d = S_RR_TOP;
        end else begin
          ret_d   = S_RR_RET;
          state_d = S_R_ISSUE;
        end
      end
      S_RR_RET: begin
        cmd_o.op = OP_RR_RET;
        state_d  = S_RR_TOP;
      end
      S_RR_END: begin
        cmd_o.op = OP_RR_END;
        state_d  = S_RR_SZ;
      end
      S_RR_SZ: begin
        cmd_o.op = OP_RR_SZ;
        state_d  = S_LINK;
      end
      S_LINK: begin
        cmd_o.op = OP_LINK;
        state_d  = S_SZ_ADD;
      end
      S_SZ_ADD: begin
        cmd_o.op = OP_SZ_ADD;
        state_d  = S_FIN;
      end
      S_EPOCH: begin
        cmd_o.op = OP_EPOCH;
        state_d  = st_i.epoch_wrap ? S_STAMP_CLR : S_MG_INIT;
      end
      S_STAMP_CLR: begin
        cmd_o.op = OP_STAMP_CLR;
        if (st_i.sweep_last) state_d = S_MG_INIT;
      end
      S_MG_INIT: begin
        cmd_o.op = OP_MG_INIT;
        state_d  = S_MG_TOP;
      end
      S_MG_TOP: begin
        if (st_i.mg_stop) begin
          state_d = S_FIN;
        end else if (!st_i.xa_none) begin
          cmd_o.op = OP_MG_SVA;
          ret_d    = S_MA_GOT;
          state_d  = S_R_ISSUE;
        end else begin
          state_d = S_MB;
        end
      end
      S_MA_GOT: begin
        cmd_o.op = OP_MARK_RD;
        state_d  = S_MA_CHK;
      end
      S_MA_CHK: begin
        cmd_o.op = OP_MA_CHK;
        state_d  = st_i.stamp_hit ? S_RW_INIT : S_MB;
      end
      S_MB: begin
        if (!st_i.xb_none) begin
          cmd_o.op = OP_MG_SVB;
          ret_d    = S_MB_GOT;
          state_d  = S_R_ISSUE;
        end else begin
          state_d = S_MG_NEXT;
        end
      end
      S_MB_GOT: begin
        cmd_o.op = OP_MARK_RD;
        state_d  = S_MB_CHK;
      end
      S_MB_CHK: begin
        cmd_o.op = OP_MB_CHK;
        state_d  = st_i.stamp_hit ? S_RW_INIT : S_MG_NEXT;
      end
      S_MG_NEXT: begin
        cmd_o.op = OP_MG_NEXT;
        state_d  = S_MG_TOP;
      end
      S_RW_INIT: begin
        cmd_o.op = OP_RW_INIT;
        state_d  = S_RW_TOP;
      end
      S_RW_TOP: begin
        if (st_i.rw_stop) begin
          state_d = S_RW_SIDE;
        end else begin
          cmd_o.op = OP_RW_SV;
          ret_d    = S_RW_GOT;
          state_d  = S_R_ISSUE;
        end
      end
      S_RW_GOT: begin
        cmd_o.op = OP_RW_GOT;
        state_d  = st_i.at_meet ? S_RW_SIDE : S_RW_NXT;
      end
      S_RW_NXT: begin
        cmd_o.op = OP_RW_NXT;
        state_d  = S_RW_TOP;
      end
      S_RW_SIDE: begin
        if (sel_q) begin
          state_d = S_FIN;
        end else begin
          sel_d   = 1'b1;
          state_d = S_RW_INIT;
        end
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      S_R_ISSUE: begin
        cmd_o.op = OP_R_START;
        state_d  = S_R_CHASE;
      end
      S_R_CHASE: begin
        cmd_o.op = OP_R_CHASE;
        if (st_i.r_stop) state_d = S_C_ISSUE;
      end
      S_C_ISSUE: begin
        cmd_o.op = OP_C_ISSUE;
        state_d  = st_i.c_stop ? ret_q : S_C_STEP;
      end
      S_C_STEP: begin
        cmd_o.op = OP_C_STEP;
        state_d  = S_C_ISSUE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// File: rtl/online_bridge_counter_unit.sv
// online_bridge_counter_unit: top level of the online bridge counter.
// Joins obc_ctrl (sequencer) and obc_dpath (memories and walk registers);
// depends on obc_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one edge per
//   transfer (vertex_a, vertex_b). Output channel out_valid_o / out_stall_i /
//   out_data_o returns one result per edge: the bridge count after the edge
//   (saturated at 1023) and the edge outcome code.
//   A transfer completes on a rising edge with valid high and stall low.
//   The block works on one edge at a time and the cost is data dependent.
//   The cost grows with each link followed in a representative chase and
//   each link compressed; each component link, re-rooted tree node and
//   cycle path step adds a representative lookup.
//   The next edge is taken in the cycle after the result register loads,
//   even while that result still waits. The receiver may stall the output
//   as long as it likes: the result holds, and a finished edge waits in its
//   last state until the register frees.
//   After reset a clearing pass initializes all tables; the input stalls
//   until it ends. When the 16-bit walk epoch wraps, one extra pass clears
//   the visit marks inside that edge.
`timescale 1ns / 1ps

module online_bridge_counter_unit #(
  parameter int unsigned NODES = obc_pkg::NODES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  obc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output obc_pkg::out_t out_data_o
);
  import obc_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer: decides one datapath operation per cycle
  obc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath: tables, walk registers and the output register
  obc_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/online_bridge_counter_unit_tb.sv
// online_bridge_counter_unit_tb: self-checking bench for the online bridge counter.
// Drives edges, predicts bridge counts and outcomes with its own forest model;
// depends on obc_pkg and online_bridge_counter_unit.
`timescale 1ns / 1ps

module online_bridge_counter_unit_tb;
  import obc_pkg::*;

  localparam int unsigned NV       = NODES_DEF;
  localparam int unsigned NO_LINK  = 32'hFFFF_FFFF;
  localparam int          N_RANDOM = 700;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  online_bridge_counter_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Forest model: parent links, component and edge-biconnected union-find, sizes.
  int unsigned forest_parent [NV];
  int unsigned comp_link     [NV];
  int unsigned tec_link      [NV];
  int unsigned comp_size     [NV];
  bit [15:0]   seen_mark     [NV];
  bit [15:0]   mark_epoch;
  int unsigned bridges;
  int unsigned path_a [NV];
  int unsigned path_b [NV];

  in_t  edge_queue [$];
  out_t result_queue [$];
  int   n_edges_total;
  int   n_accepted = 0;
  int   n_mismatch = 0;
  bit   in_fire = 1'b0;

  function automatic void clear_forest();
    for (int i = 0; i < NV; i++) begin
      forest_parent[i] = NO_LINK;
      comp_link[i]     = i;
      tec_link[i]      = i;
      comp_size[i]     = 1;
      seen_mark[i]     = '0;
    end
    mark_epoch = '0;
    bridges    = 0;
  endfunction

  // Find the edge-biconnected representative and compress the chain behind it.
  function automatic int unsigned tec_root(int unsigned v);
    int unsigned r, u, nx;
    if (v >= NV) return NO_LINK;
    r = v;
    for (int i = 0; i < NV && tec_link[r] != r; i++) r = tec_link[r];
    u = v;
    for (int i = 0; i < NV && u != r; i++) begin
      nx = tec_link[u];
      tec_link[u] = r;
      u = nx;
    end
    return r;
  endfunction

  function automatic int unsigned comp_root(int unsigned v);
    int unsigned r, u, nx;
    r = tec_root(v);
    for (int i = 0; i < NV && comp_link[r] != r; i++) r = tec_root(comp_link[r]);
    u = tec_root(v);
    for (int i = 0; i < NV && u != r; i++) begin
      nx = comp_link[u];
      comp_link[u] = r;
      u = tec_root(nx);
    end
    return r;
  endfunction

  // Reverse the parent chain so that v becomes the root of its tree.
  function automatic void evert_tree(int unsigned v);
    int unsigned top, child, p;
    child = NO_LINK;
    v = tec_root(v);
    top = v;
    for (int i = 0; i < NV && v != NO_LINK; i++) begin
      p = tec_root(forest_parent[v]);
      forest_parent[v] = child;
      comp_link[v] = top;
      child = v;
      v = p;
    end
    if (child != NO_LINK) comp_size[top] = comp_size[child];
  endfunction

  // Walk both endpoints upward until they meet, then fold the path.
  function automatic void fold_cycle(int unsigned a, int unsigned b);
    int unsigned meet, la, lb, v;
    bit hit;
    meet = NO_LINK; la = 0; lb = 0; hit = 0;
    mark_epoch = mark_epoch + 16'd1;
    if (mark_epoch == 0) begin
      for (int i = 0; i < NV; i++) seen_mark[i] = '0;
      mark_epoch = 16'd1;
    end
    for (int s = 0; s <= 2 * NV && !hit; s++) begin
      if (a == NO_LINK && b == NO_LINK) break;
      if (a != NO_LINK) begin
        v = tec_root(a);
        if (v == NO_LINK) a = NO_LINK;
        else begin
          if (la < NV) begin path_a[la] = v; la++; end
          if (seen_mark[v] == mark_epoch) begin meet = v; hit = 1; end
          else begin seen_mark[v] = mark_epoch; a = forest_parent[v]; end
        end
      end
      if (!hit && b != NO_LINK) begin
        v = tec_root(b);
        if (v == NO_LINK) b = NO_LINK;
        else begin
          if (lb < NV) begin path_b[lb] = v; lb++; end
          if (seen_mark[v] == mark_epoch) begin meet = v; hit = 1; end
          else begin seen_mark[v] = mark_epoch; b = forest_parent[v]; end
        end
      end
    end
    if (meet == NO_LINK) return;
    for (int i = 0; i < la; i++) begin
      tec_link[path_a[i]] = meet;
      if (path_a[i] == meet) break;
      if (bridges > 0) bridges--;
    end
    for (int i = 0; i < lb; i++) begin
      tec_link[path_b[i]] = meet;
      if (path_b[i] == meet) break;
      if (bridges > 0) bridges--;
    end
  endfunction

  function automatic out_t predict_edge(in_t e);
    int unsigned a, b, ca, cb, t;
    out_t r;
    r.edge_outcome = OUTC_SAME;
    a = e.vertex_a;
    b = e.vertex_b;
    if (a < NV && b < NV) begin
      a = tec_root(a);
      b = tec_root(b);
      if (a != b) begin
        ca = comp_root(a);
        cb = comp_root(b);
        if (ca != cb) begin
          bridges++;
          if (comp_size[ca] > comp_size[cb]) begin
            t = a; a = b; b = t;
            t = ca; ca = cb; cb = t;
          end
          evert_tree(a);
          forest_parent[a] = b;
          comp_link[a] = b;
          comp_size[cb] += comp_size[a];
          r.edge_outcome = OUTC_BRIDGE;
        end else begin
          fold_cycle(a, b);
          r.edge_outcome = OUTC_CYCLE;
        end
      end
    end
    r.bridge_count = (bridges > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : bridges[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void push_edge(int unsigned a, int unsigned b);
    in_t e;
    e.vertex_a = a[VERT_W-1:0];
    e.vertex_b = b[VERT_W-1:0];
    edge_queue.insert(edge_queue.size(), e);
  endfunction

  // Idle rates per phase: sender 10 / receiver 48, then swapped, then none.
  function automatic int send_idle_pct();
    if (n_accepted < n_edges_total / 3) return 10;
    if (n_accepted < 2 * n_edges_total / 3) return 48;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_accepted < n_edges_total / 3) return 48;
    if (n_accepted < 2 * n_edges_total / 3) return 10;
    return 0;
  endfunction

  // Driver: advance on the falling edge; hold the payload while stalled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (edge_queue.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          in_data  <= edge_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct());
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk) begin
    out_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      result_queue.insert(result_queue.size(), predict_edge(in_data));
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        n_mismatch <= n_mismatch + 1;
        if (n_mismatch < 10)
          $display("unexpected result: count %0d outcome %0d",
                   out_data.bridge_count, out_data.edge_outcome);
      end else begin
        want = result_queue.pop_front();
        if (out_data.bridge_count !== want.bridge_count ||
            out_data.edge_outcome !== want.edge_outcome) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10)
            $display("mismatch: count exp %0d got %0d, outcome exp %0d got %0d",
                     want.bridge_count, out_data.bridge_count,
                     want.edge_outcome, out_data.edge_outcome);
        end
      end
    end
  end

  initial begin
    int unsigned win_base, a, b, pick;
    clear_forest();

    // Directed: extremes, bridges, cycles, self loop, same-component edges.
    push_edge(0, 1023);
    push_edge(1023, 0);
    push_edge(0, 1023);
    push_edge(5, 5);
    push_edge(1, 2);
    push_edge(2, 3);
    push_edge(3, 1);
    push_edge(3, 4);
    push_edge(4, 5);
    push_edge(5, 1);
    push_edge(1, 4);
    push_edge(6, 7);
    push_edge(8, 9);
    push_edge(7, 9);
    push_edge(1, 6);
    push_edge(9, 2);
    push_edge(341, 682);
    push_edge(682, 1023);
    push_edge(341, 0);
    push_edge(512, 511);
    push_edge(511, 1);
    push_edge(512, 8);

    // Random: mostly edges inside a small sliding window so cycles form often.
    win_base = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 120 == 0) win_base = $urandom_range(NV - 40);
      pick = $urandom_range(99);
      if (pick < 80) begin
        a = win_base + $urandom_range(39);
        b = win_base + $urandom_range(39);
      end else if (pick < 90) begin
        a = $urandom_range(NV - 1);
        b = $urandom_range(NV - 1);
      end else if (pick < 95) begin
        a = $urandom_range(NV - 1);
        b = a;
      end else begin
        a = $urandom_range(1) ? NV - 1 : 0;
        b = $urandom_range(NV - 1);
      end
      push_edge(a, b);
    end
    n_edges_total = edge_queue.size();

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Drain: all edges sent, all results seen, then a short settle.
    wait (edge_queue.size() == 0 && !in_valid && result_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (n_mismatch == 0 && result_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/obc_pkg.sv
rtl/obc_dpath.sv
rtl/obc_ctrl.sv
rtl/online_bridge_counter_unit.sv
tb/online_bridge_counter_unit_tb.sv
